>>> hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, c)
`define ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/edid_pkg.sv
package edid_pkg;

  localparam int unsigned TextCap = 13;

  localparam logic [7:0] TagName   = 8'hFC;
  localparam logic [7:0] TagSerial = 8'hFF;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [4:0] KindError     = 5'd0;
  localparam logic [4:0] KindMfr       = 5'd1;
  localparam logic [4:0] KindProduct   = 5'd2;
  localparam logic [4:0] KindSerial    = 5'd3;
  localparam logic [4:0] KindWeek      = 5'd4;
  localparam logic [4:0] KindYear      = 5'd5;
  localparam logic [4:0] KindVersion   = 5'd6;
  localparam logic [4:0] KindRevision  = 5'd7;
  localparam logic [4:0] KindDigital   = 5'd8;
  localparam logic [4:0] KindExt       = 5'd9;
  localparam logic [4:0] KindClock     = 5'd10;
  localparam logic [4:0] KindWidth     = 5'd11;
  localparam logic [4:0] KindHeight    = 5'd12;
  localparam logic [4:0] KindWidthMm   = 5'd13;
  localparam logic [4:0] KindHeightMm  = 5'd14;
  localparam logic [4:0] KindNameLo    = 5'd15;
  localparam logic [4:0] KindNameHi    = 5'd16;
  localparam logic [4:0] KindSerTextLo = 5'd17;
  localparam logic [4:0] KindSerTextHi = 5'd18;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  result_kind;
    logic [63:0] field_value;
    logic        last_result;
  } out_word_t;

endpackage

>>> hdl/edid_base_block_parser.sv
// EDID base-block parser. One byte word is taken per cycle while in_stall_o is low; the last byte
// of a buffer carries end_of_buffer. After byte 127 the block emits 18 result words (kinds 1..18,
// the last flagged), one per cycle while the receiver does not stall, from the captured field
// registers; input is stalled until all 18 have been taken. A result word held by a stalled
// receiver also stalls the input. A short buffer or a failed header/checksum yields one error
// word. Bytes beyond 127 are dropped until end_of_buffer, which restarts the parser.
`include "assert_macros.svh"
module edid_base_block_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  edid_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output edid_pkg::out_word_t  out_word_o
);

  logic [6:0]        off_q, off_d;
  logic              done_q, done_d;
  logic [7:0]        sum_q, sum_d;
  logic              hdr_q, hdr_d;
  logic [13:0][7:0]  id_q, id_d;
  logic [17:0][7:0]  s0_q, s0_d;
  logic              s0tim_q, s0tim_d;
  logic              tim_q, tim_d;
  logic [7:0]        tag_q, tag_d;
  logic [12:0][7:0]  name_q, name_d;
  logic [12:0][7:0]  ser_q, ser_d;
  logic [3:0]        nlen_q, nlen_d;
  logic [3:0]        slen_q, slen_d;
  logic [3:0]        tidx_q, tidx_d;
  logic [3:0]        nz_q, nz_d;
  logic              stop_q, stop_d;
  logic [4:0]        pos_q, pos_d;
  logic              busy_q, busy_d;
  logic              pend_q, pend_d;
  logic [4:0]        kind_q, kind_d;
  logic              ovld_q, ovld_d;
  edid_pkg::out_word_t oword_q, oword_d;

  logic       acc, oload;
  logic [7:0] b;
  logic       eob;
  logic       restart;

  assign oload      = !ovld_q || !out_stall_i;
  assign in_stall_o = busy_q || !oload;
  assign acc        = in_valid_i && !in_stall_o;
  assign b          = in_word_i.data_byte;
  assign eob        = in_word_i.end_of_buffer;

  function automatic logic [63:0] pack_text(logic [12:0][7:0] ch, logic [3:0] len,
                                            logic [3:0] first, logic [3:0] cnt);
    logic [63:0] v;
    logic [4:0]  idx;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      idx = 5'(first) + 5'(i);
      if (4'(i) < cnt && idx < 5'(edid_pkg::TextCap) && idx < 5'(len)) begin
        v[8*i +: 8] = ch[idx[3:0]];
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] field_of(logic [4:0] k);
    logic [63:0] v;
    logic [15:0] m;
    m = {id_q[0], id_q[1]};
    v = '0;
    case (k)
      edid_pkg::KindMfr: v = 64'({8'h40 + {3'd0, m[4:0]}, 8'h40 + {3'd0, m[9:5]},
                                  8'h40 + {3'd0, m[14:10]}});
      edid_pkg::KindProduct:  v = 64'({id_q[3], id_q[2]});
      edid_pkg::KindSerial:   v = 64'({id_q[7], id_q[6], id_q[5], id_q[4]});
      edid_pkg::KindWeek:     v = 64'(id_q[8]);
      edid_pkg::KindYear:     v = 64'(12'd1990 + 12'(id_q[9]));
      edid_pkg::KindVersion:  v = 64'(id_q[10]);
      edid_pkg::KindRevision: v = 64'(id_q[11]);
      edid_pkg::KindDigital:  v = 64'(id_q[12][7]);
      edid_pkg::KindExt:      v = 64'(id_q[13]);
      edid_pkg::KindClock:
        v = s0tim_q ? 64'(20'({s0_q[1], s0_q[0]}) * 20'd10) : '0;
      edid_pkg::KindWidth:    v = s0tim_q ? 64'({s0_q[4][7:4], s0_q[2]}) : '0;
      edid_pkg::KindHeight:   v = s0tim_q ? 64'({s0_q[7][7:4], s0_q[5]}) : '0;
      edid_pkg::KindWidthMm:  v = s0tim_q ? 64'({s0_q[14][7:4], s0_q[12]}) : '0;
      edid_pkg::KindHeightMm: v = s0tim_q ? 64'({s0_q[14][3:0], s0_q[13]}) : '0;
      edid_pkg::KindNameLo:   v = pack_text(name_q, nlen_q, 4'd0, 4'd8);
      edid_pkg::KindNameHi:
        v = pack_text(name_q, nlen_q, 4'd8, 4'd5) | (64'(nlen_q) << 40);
      edid_pkg::KindSerTextLo: v = pack_text(ser_q, slen_q, 4'd0, 4'd8);
      edid_pkg::KindSerTextHi:
        v = pack_text(ser_q, slen_q, 4'd8, 4'd5) | (64'(slen_q) << 40);
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    off_d = off_q; done_d = done_q; sum_d = sum_q; hdr_d = hdr_q;
    id_d = id_q; s0_d = s0_q; s0tim_d = s0tim_q; tim_d = tim_q; tag_d = tag_q;
    name_d = name_q; ser_d = ser_q; nlen_d = nlen_q; slen_d = slen_q;
    tidx_d = tidx_q; nz_d = nz_q; stop_d = stop_q; pos_d = pos_q;
    busy_d = busy_q; pend_d = pend_q; kind_d = kind_q;
    ovld_d = ovld_q && out_stall_i;
    oword_d = oword_q;
    restart = 1'b0;

    if (busy_q && oload) begin
      ovld_d = 1'b1;
      oword_d.result_kind = kind_q;
      oword_d.field_value = field_of(kind_q);
      oword_d.last_result = (kind_q == edid_pkg::KindSerTextHi);
      kind_d = kind_q + 5'd1;
      if (kind_q == edid_pkg::KindSerTextHi) begin
        busy_d = 1'b0;
        restart = pend_q;
      end
    end

    if (acc) begin
      if (done_q) begin
        restart = eob;
      end else begin
        sum_d = sum_q + b;
        if (off_q < 7'd8) begin
          if (b != ((off_q == 7'd0 || off_q == 7'd7) ? 8'h00 : 8'hFF)) hdr_d = 1'b0;
        end
        if (off_q >= 7'd8 && off_q <= 7'd20) id_d[4'(off_q - 7'd8)] = b;
        if (off_q == 7'd126) id_d[13] = b;
        if (off_q >= 7'd54 && off_q < 7'd126) begin
          pos_d = (pos_q == 5'd17) ? 5'd0 : pos_q + 5'd1;
          if (off_q < 7'd72) s0_d[pos_q] = b;
          if (pos_q == 5'd0) begin
            tim_d = (b != 8'd0);
          end else if (pos_q == 5'd1) begin
            if (b != 8'd0) tim_d = 1'b1;
            if (off_q < 7'd72) s0tim_d = tim_d;
          end else if (pos_q == 5'd3) begin
            tag_d = tim_q ? 8'd0 : b;
          end else if (pos_q == 5'd4) begin
            tidx_d = 4'd0; stop_d = 1'b0; nz_d = 4'd0;
          end else if (pos_q >= 5'd5 &&
                       (tag_q == edid_pkg::TagName || tag_q == edid_pkg::TagSerial)) begin
            if (!stop_q) begin
              if (b == edid_pkg::CharLf) begin
                stop_d = 1'b1;
              end else if (tidx_q < 4'(edid_pkg::TextCap)) begin
                if (tag_q == edid_pkg::TagName) name_d[tidx_q] = b;
                else ser_d[tidx_q] = b;
                tidx_d = tidx_q + 4'd1;
                if (b != edid_pkg::CharSpace) nz_d = tidx_q + 4'd1;
              end
            end
            if (pos_q == 5'd17) begin
              if (tag_q == edid_pkg::TagName) nlen_d = nz_d;
              else slen_d = nz_d;
            end
          end
        end
        off_d = off_q + 7'd1;
        if (off_q == 7'd127) begin
          done_d = 1'b1;
          if (!hdr_d || sum_d != 8'd0) begin
            ovld_d = 1'b1;
            oword_d = '{result_kind: edid_pkg::KindError, field_value: '0, last_result: 1'b1};
            restart = eob;
          end else begin
            busy_d = 1'b1;
            kind_d = edid_pkg::KindMfr;
            pend_d = eob;
          end
        end else if (eob) begin
          ovld_d = 1'b1;
          oword_d = '{result_kind: edid_pkg::KindError, field_value: '0, last_result: 1'b1};
          restart = 1'b1;
        end
      end
    end

    if (restart) begin
      off_d = '0; done_d = 1'b0; sum_d = '0; hdr_d = 1'b1; s0tim_d = 1'b0;
      tim_d = 1'b0; tag_d = '0; nlen_d = '0; slen_d = '0; tidx_d = '0;
      nz_d = '0; stop_d = 1'b0; pos_d = '0; pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; done_q <= 1'b0; sum_q <= '0; hdr_q <= 1'b1; s0tim_q <= 1'b0;
      tim_q <= 1'b0; tag_q <= '0; nlen_q <= '0; slen_q <= '0; tidx_q <= '0;
      nz_q <= '0; stop_q <= 1'b0; pos_q <= '0; busy_q <= 1'b0; pend_q <= 1'b0;
      kind_q <= '0; ovld_q <= 1'b0;
    end else begin
      off_q <= off_d; done_q <= done_d; sum_q <= sum_d; hdr_q <= hdr_d; s0tim_q <= s0tim_d;
      tim_q <= tim_d; tag_q <= tag_d; nlen_q <= nlen_d; slen_q <= slen_d; tidx_q <= tidx_d;
      nz_q <= nz_d; stop_q <= stop_d; pos_q <= pos_d; busy_q <= busy_d; pend_q <= pend_d;
      kind_q <= kind_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; s0_q <= s0_d; name_q <= name_d; ser_q <= ser_d; oword_q <= oword_d;
  end

  assign out_valid_o = ovld_q;
  assign out_word_o  = oword_q;

  `ASSERT_IMP(a_busy_stalls, clk_i, rst_ni, busy_q, in_stall_o)
  `ASSERT_IMP(a_busy_not_last, clk_i, rst_ni, busy_q && ovld_q, !oword_q.last_result)
  `ASSERT_IMP(a_err_last, clk_i, rst_ni, ovld_q && oword_q.result_kind == edid_pkg::KindError, oword_q.last_result)
  `ASSERT_NXT(a_busy_done, clk_i, rst_ni, busy_q, done_q || !busy_q)

endmodule

>>> bench/edid_base_block_parser_tb.sv
module edid_base_block_parser_tb;

  // Scoreboard: holds a copy of the parser state and the queue of words still owed.
  class edid_scoreboard;
    edid_pkg::out_word_t owed_q[$];
    int         errors;
    logic [6:0] offset;
    bit         complete;
    logic [7:0] sum;
    bit         hdr_ok;
    logic [7:0] ident[14];
    logic [7:0] slot0[18];
    bit         slot0_timing;
    bit         cur_timing;
    logic [7:0] tag;
    logic [7:0] name_c[13];
    logic [7:0] ser_c[13];
    logic [3:0] name_len;
    logic [3:0] ser_len;
    logic [3:0] tidx;
    bit         stopped;

    function void clear();
      offset = '0; complete = 0; sum = '0; hdr_ok = 1;
      foreach (ident[i]) ident[i] = '0;
      foreach (slot0[i]) slot0[i] = '0;
      slot0_timing = 0; cur_timing = 0; tag = '0;
      foreach (name_c[i]) begin
        name_c[i] = '0;
        ser_c[i] = '0;
      end
      name_len = '0; ser_len = '0; tidx = '0; stopped = 0;
    endfunction

    function logic [63:0] pack_chars(bit use_name, int first, int count);
      logic [63:0] v;
      int idx;
      v = '0;
      for (int i = 0; i < count; i++) begin
        idx = first + i;
        if (idx < 13 && idx < (use_name ? name_len : ser_len))
          v[8*i +: 8] = use_name ? name_c[idx] : ser_c[idx];
      end
      return v;
    endfunction

    function void owe(logic [4:0] kind, logic [63:0] val, bit last);
      edid_pkg::out_word_t w;
      w.result_kind = kind; w.field_value = val; w.last_result = last;
      owed_q.push_back(w);
    endfunction

    function void emit_fields();
      logic [15:0] m;
      logic [63:0] v;
      m = {ident[0], ident[1]};
      owe(edid_pkg::KindMfr,
          {40'd0, 3'b010, m[4:0], 3'b010, m[9:5], 3'b010, m[14:10]}, 0);
      owe(edid_pkg::KindProduct, {48'd0, ident[3], ident[2]}, 0);
      owe(edid_pkg::KindSerial, {32'd0, ident[7], ident[6], ident[5], ident[4]}, 0);
      owe(edid_pkg::KindWeek, {56'd0, ident[8]}, 0);
      owe(edid_pkg::KindYear, 64'd1990 + ident[9], 0);
      owe(edid_pkg::KindVersion, {56'd0, ident[10]}, 0);
      owe(edid_pkg::KindRevision, {56'd0, ident[11]}, 0);
      owe(edid_pkg::KindDigital, {63'd0, ident[12][7]}, 0);
      owe(edid_pkg::KindExt, {56'd0, ident[13]}, 0);
      owe(edid_pkg::KindClock,
          slot0_timing ? {48'd0, slot0[1], slot0[0]} * 64'd10 : '0, 0);
      owe(edid_pkg::KindWidth,
          slot0_timing ? {52'd0, slot0[4][7:4], slot0[2]} : '0, 0);
      owe(edid_pkg::KindHeight,
          slot0_timing ? {52'd0, slot0[7][7:4], slot0[5]} : '0, 0);
      owe(edid_pkg::KindWidthMm,
          slot0_timing ? {52'd0, slot0[14][7:4], slot0[12]} : '0, 0);
      owe(edid_pkg::KindHeightMm,
          slot0_timing ? {52'd0, slot0[14][3:0], slot0[13]} : '0, 0);
      owe(edid_pkg::KindNameLo, pack_chars(1, 0, 8), 0);
      v = pack_chars(1, 8, 5); v[47:40] = name_len;
      owe(edid_pkg::KindNameHi, v, 0);
      owe(edid_pkg::KindSerTextLo, pack_chars(0, 0, 8), 0);
      v = pack_chars(0, 8, 5); v[47:40] = ser_len;
      owe(edid_pkg::KindSerTextHi, v, 1);
    endfunction

    function void slot_byte(int slot, int pos, logic [7:0] b);
      int j;
      bit is_name;
      if (slot == 0) slot0[pos] = b;
      if (pos == 0) cur_timing = (b != 0);
      else if (pos == 1) begin
        if (b != 0) cur_timing = 1;
        if (slot == 0) slot0_timing = cur_timing;
      end else if (pos == 3) tag = cur_timing ? 8'h00 : b;
      else if (pos == 4) begin
        tidx = 0; stopped = 0;
      end else if (pos >= 5 && (tag == edid_pkg::TagName || tag == edid_pkg::TagSerial)) begin
        is_name = (tag == edid_pkg::TagName);
        if (!stopped) begin
          if (b == edid_pkg::CharLf) stopped = 1;
          else if (tidx < edid_pkg::TextCap) begin
            if (is_name) name_c[tidx] = b; else ser_c[tidx] = b;
            tidx++;
          end
        end
        if (pos == 17) begin
          j = tidx;
          while (j > 0 && (is_name ? name_c[j-1] : ser_c[j-1]) == edid_pkg::CharSpace) j--;
          if (is_name) name_len = j; else ser_len = j;
        end
      end
    endfunction

    function void note_input(edid_pkg::in_word_t w);
      logic [7:0] b;
      int off;
      b = w.data_byte; off = offset;
      if (complete) begin
        if (w.end_of_buffer) clear();
        return;
      end
      sum += b;
      if (off < 8 && b != ((off == 0 || off == 7) ? 8'h00 : 8'hFF)) hdr_ok = 0;
      if (off >= 8 && off <= 20) ident[off-8] = b;
      if (off == 126) ident[13] = b;
      if (off >= 54 && off < 126) slot_byte((off - 54) / 18, (off - 54) % 18, b);
      if (off == 127) begin
        complete = 1;
        if (!hdr_ok || sum != 0) owe(edid_pkg::KindError, '0, 1);
        else emit_fields();
        if (w.end_of_buffer) clear();
        return;
      end
      offset = offset + 1;
      if (w.end_of_buffer) begin
        owe(edid_pkg::KindError, '0, 1);
        clear();
      end
    endfunction

    function void check_result(edid_pkg::out_word_t got);
      edid_pkg::out_word_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected word kind=%0d value=%h", got.result_kind, got.field_value);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.field_value !== want.field_value) begin
        $error("field_value: expected %h, got %h", want.field_value, got.field_value);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  edid_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  edid_pkg::out_word_t out_word_o;

  edid_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int sent_items;

  edid_base_block_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_word_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, bit eob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_word_i.data_byte <= b;
    in_word_i.end_of_buffer <= eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input('{data_byte: b, end_of_buffer: eob});
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_text_char();
    int r;
    r = $urandom_range(9);
    if (r == 0) return edid_pkg::CharLf;
    if (r < 3) return edid_pkg::CharSpace;
    return 8'($urandom_range(32, 126));
  endfunction

  // Builds and sends one 128-byte block; mode 0 valid, 1 bad header, 2 bad sum, 3 random noise.
  task automatic send_block(int mode, int extra, bit short_cut, int cut_at);
    logic [7:0] blk[128];
    logic [7:0] s;
    int kind;
    foreach (blk[i]) blk[i] = 8'($urandom);
    blk[0] = 8'h00; blk[7] = 8'h00;
    for (int i = 1; i < 7; i++) blk[i] = 8'hFF;
    for (int sl = 0; sl < 4; sl++) begin
      kind = $urandom_range(3);
      if (kind != 0) begin
        blk[54 + 18*sl] = 8'h00;
        blk[55 + 18*sl] = ($urandom_range(5) == 0) ? 8'h01 : 8'h00;
        blk[57 + 18*sl] = (kind == 1) ? edid_pkg::TagName :
                          (kind == 2) ? edid_pkg::TagSerial : 8'($urandom);
        for (int p = 5; p < 18; p++) blk[54 + 18*sl + p] = rand_text_char();
      end
    end
    if (mode == 1) blk[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
    s = 0;
    for (int i = 0; i < 127; i++) s += blk[i];
    blk[127] = -s;
    if (mode == 2) blk[127] += 8'($urandom_range(1, 255));
    if (mode == 3) foreach (blk[i]) blk[i] = 8'($urandom);
    for (int i = 0; i < 128; i++) begin
      if (short_cut && i == cut_at) begin
        send_byte(blk[i], 1);
        return;
      end
      send_byte(blk[i], (extra == 0 && i == 127));
    end
    for (int i = 0; i < extra; i++) send_byte(8'($urandom), i == extra - 1);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 0;
    in_valid_i = 0;
    in_word_i = '0;
    out_stall_i = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_items = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: short buffers of one and two bytes
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(8'h00, 0);
    send_byte(8'hFF, 1);
    wait_drained();

    // one block per phase; the sender pauses until everything owed has come back
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 79) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 79) : 0;
      case (ph)
        0: send_block($urandom_range(1, 3), 1, 0, 0);
        1: send_block(0, 0, 1, $urandom_range(40, 60));
        2: send_block(0, 0, 0, 0);
        default: send_block(0, 0, 1, $urandom_range(40, 70));
      endcase
      send_idle_pct = 0;
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
